// ----- design/bchd_pkg.sv -----
package bchd_pkg;

  localparam int BUTTONS_DEFAULT = 4;
  localparam int BIDX_W          = 4;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;
  localparam int MAX_REPORTS     = 8;
  localparam int RPT_CNT_W       = 4;
  localparam int HOLD_STEP_DIV   = 5;

  // 16-bit x / 5 == (x * 0xCCCD) >> 18 for every 16-bit x
  localparam logic [31:0] DIV5_RECIP = 32'h0000_CCCD;
  localparam int          DIV5_SHIFT = 18;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic PRESS_LEVEL_RST = 1'b0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE_SAMPLES   = 3'd0,
    CFG_PRESS_LEVEL        = 3'd1,
    CFG_HOLD_PERIOD_TICKS  = 3'd2,
    CFG_RELEASE_WAIT_TICKS = 3'd3,
    CFG_CLICK_CODE_LIMIT   = 3'd4,
    CFG_HOLD_CODE_LIMIT    = 3'd5,
    CFG_UNKNOWN_CODE       = 3'd6
  } cfg_index_t;

  typedef enum logic [1:0] {
    KIND_HOLD_PROGRESS = 2'd0,
    KIND_CLICK_COUNT   = 2'd1,
    KIND_HOLD_CODE     = 2'd2
  } report_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MODIFY,
    ST_FLUSH
  } ctrl_state_t;

  typedef enum logic [1:0] {
    PASS_SAMPLE,
    PASS_HOLD,
    PASS_RELEASE
  } pass_t;

  typedef struct packed {
    logic        stable_level;
    logic        previous_sample;
    logic [7:0]  equal_run;
    logic [7:0]  click_count;
    logic [15:0] hold_steps;
    logic        is_pressed;
    logic        is_released;
    logic        is_holding;
  } btn_state_t;

  localparam btn_state_t ENTRY_RESET = '{
    stable_level:    ~PRESS_LEVEL_RST,
    previous_sample: ~PRESS_LEVEL_RST,
    equal_run:       8'd0,
    click_count:     8'd0,
    hold_steps:      16'd0,
    is_pressed:      1'b0,
    is_released:     1'b0,
    is_holding:      1'b0
  };

  typedef struct packed {
    logic              push;
    logic              flush;
    logic [BIDX_W-1:0] button;
    report_kind_t      kind;
    logic [7:0]        code;
  } rpt_req_t;

  function automatic logic [13:0] div5(input logic [15:0] x);
    logic [31:0] p;
    p = {16'd0, x} * DIV5_RECIP;
    return p[DIV5_SHIFT +: 14];
  endfunction

  function automatic logic [15:0] at_least_one(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

endpackage

// ----- design/bchd_if.sv -----
interface bchd_item_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [3:0] button_index;
  logic       pin_level;

  modport source (output valid, output op, output button_index, output pin_level,
                  input ready);
  modport sink   (input valid, input op, input button_index, input pin_level,
                  output ready);
endinterface

interface bchd_report_if;
  logic       valid;
  logic       ready;
  logic [3:0] button_index_res;
  logic [1:0] report_kind;
  logic [7:0] report_code;
  logic       last;

  modport source (output valid, output button_index_res, output report_kind,
                  output report_code, output last, input ready);
  modport sink   (input valid, input button_index_res, input report_kind,
                  input report_code, input last, output ready);
endinterface

// ----- design/bchd_ram.sv -----
module bchd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/bchd_rpt.sv -----
module bchd_rpt (
  input  logic                clk,
  input  logic                rst,
  input  bchd_pkg::rpt_req_t  req,
  output logic                ready,
  bchd_report_if.source       reports
);

  logic                        pend_valid;
  logic [bchd_pkg::BIDX_W-1:0] pend_button;
  bchd_pkg::report_kind_t      pend_kind;
  logic [7:0]                  pend_code;
  logic                        out_free;
  logic                        load_out;

  assign out_free = !reports.valid || reports.ready;
  assign ready    = !pend_valid || out_free;
  // the held report moves out once its successor or the end of the item is known
  assign load_out = pend_valid && ready && (req.push || req.flush);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid    <= 1'b0;
      reports.valid <= 1'b0;
    end else begin
      if (load_out) begin
        reports.valid <= 1'b1;
      end else if (reports.ready) begin
        reports.valid <= 1'b0;
      end
      if (req.push && ready) begin
        pend_valid <= 1'b1;
      end else if (req.flush && ready) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      reports.button_index_res <= pend_button;
      reports.report_kind      <= pend_kind;
      reports.report_code      <= pend_code;
      reports.last             <= req.flush;
    end
    if (req.push && ready) begin
      pend_button <= req.button;
      pend_kind   <= req.kind;
      pend_code   <= req.code;
    end
  end

endmodule

// ----- design/bchd_ctrl.sv -----
module bchd_ctrl #(
  parameter int BUTTONS = bchd_pkg::BUTTONS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [bchd_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [bchd_pkg::CFG_DATA_W-1:0] wr_data,
  bchd_item_if.sink                       items,
  output bchd_pkg::rpt_req_t              req,
  input  logic                            rpt_ready
);

  localparam int AW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
  localparam int SW = $bits(bchd_pkg::btn_state_t);

  // configuration
  logic [7:0]  debounce_samples;
  logic        press_level;
  logic [15:0] hold_period_ticks;
  logic [15:0] release_wait_ticks;
  logic [7:0]  click_code_limit;
  logic [7:0]  hold_code_limit;
  logic [7:0]  unknown_code;

  // shared timers
  logic [15:0] hold_timer;
  logic        hold_timer_on;
  logic [15:0] release_timer;
  logic        release_timer_on;

  bchd_pkg::ctrl_state_t state, state_next;
  bchd_pkg::pass_t       pass;
  logic [AW-1:0]                  btn;
  logic                           level;
  logic                           any_pressed;
  logic                           fire_rel_q;
  logic [bchd_pkg::RPT_CNT_W-1:0] rpt_cnt;
  logic [BUTTONS-1:0]             written;
  logic                           rd_valid;

  logic [SW-1:0]          ram_q;
  bchd_pkg::btn_state_t   cur, nxt;

  logic        item_fire;
  logic        is_tick;
  logic        in_range;
  logic [15:0] hold_dec;
  logic [15:0] rel_dec;
  logic        fire_hold;
  logic        fire_rel;
  logic        last_btn;

  logic [15:0] hs_inc;
  logic [15:0] div_in;
  logic [13:0] quot;
  logic        rem_zero;
  logic [14:0] code_sum;
  logic [7:0]  run_n;
  logic        accept_lvl;

  logic                   rep_gen;
  bchd_pkg::report_kind_t rep_kind;
  logic [7:0]             rep_code;
  logic                   press_evt;
  logic                   release_evt;
  logic                   any_next;
  logic                   emit;
  logic                   stall;
  logic                   step;

  assign items.ready = (state == bchd_pkg::ST_IDLE);
  assign item_fire   = items.valid && items.ready;
  assign is_tick     = (items.op == bchd_pkg::OP_TICK);
  assign in_range    = {1'b0, items.button_index} < 5'(BUTTONS);

  assign hold_dec  = (hold_timer != 16'd0) ? hold_timer - 16'd1 : 16'd0;
  assign rel_dec   = (release_timer != 16'd0) ? release_timer - 16'd1 : 16'd0;
  assign fire_hold = hold_timer_on && (hold_dec == 16'd0);
  assign fire_rel  = release_timer_on && (rel_dec == 16'd0);
  assign last_btn  = (btn == AW'(BUTTONS - 1));

  assign cur = rd_valid ? bchd_pkg::btn_state_t'(ram_q) : bchd_pkg::ENTRY_RESET;

  assign hs_inc   = (cur.hold_steps != 16'hFFFF) ? cur.hold_steps + 16'd1 : cur.hold_steps;
  assign div_in   = (pass == bchd_pkg::PASS_HOLD) ? hs_inc : cur.hold_steps;
  assign quot     = bchd_pkg::div5(div_in);
  assign rem_zero = (div_in == ({quot, 2'b00} + {2'b00, quot}));
  assign code_sum = {1'b0, quot} + {7'd0, click_code_limit};

  assign run_n = (level == cur.previous_sample)
                 ? ((cur.equal_run != 8'hFF) ? cur.equal_run + 8'd1 : cur.equal_run)
                 : 8'd1;
  assign accept_lvl = (run_n >= debounce_samples) && (level != cur.stable_level);

  always_comb begin
    nxt         = cur;
    rep_gen     = 1'b0;
    rep_kind    = bchd_pkg::KIND_HOLD_PROGRESS;
    rep_code    = 8'd0;
    press_evt   = 1'b0;
    release_evt = 1'b0;
    any_next    = any_pressed;
    case (pass)
      bchd_pkg::PASS_SAMPLE: begin
        nxt.equal_run       = run_n;
        nxt.previous_sample = level;
        if (accept_lvl) begin
          nxt.stable_level = level;
          if (level == press_level) begin
            press_evt       = 1'b1;
            nxt.click_count = (cur.click_count != 8'hFF) ? cur.click_count + 8'd1
                                                         : cur.click_count;
            nxt.is_holding  = 1'b0;
            nxt.hold_steps  = 16'd0;
            nxt.is_pressed  = 1'b1;
            nxt.is_released = 1'b0;
          end else begin
            release_evt     = 1'b1;
            nxt.is_released = 1'b1;
            nxt.is_pressed  = 1'b0;
          end
        end
      end
      bchd_pkg::PASS_HOLD: begin
        if (cur.is_pressed) begin
          any_next       = 1'b1;
          nxt.hold_steps = hs_inc;
          if (hs_inc >= 16'(bchd_pkg::HOLD_STEP_DIV)) begin
            nxt.is_holding  = 1'b1;
            nxt.click_count = 8'd0;
          end
          if (rem_zero) begin
            rep_gen  = 1'b1;
            rep_kind = bchd_pkg::KIND_HOLD_PROGRESS;
            rep_code = (code_sum > 15'd255) ? 8'hFF : code_sum[7:0];
          end
        end
      end
      bchd_pkg::PASS_RELEASE: begin
        if (cur.is_released) begin
          rep_gen = 1'b1;
          if (!cur.is_holding) begin
            rep_kind = bchd_pkg::KIND_CLICK_COUNT;
            rep_code = (cur.click_count >= click_code_limit) ? unknown_code
                                                             : cur.click_count;
          end else begin
            rep_kind = bchd_pkg::KIND_HOLD_CODE;
            rep_code = (code_sum >= {7'd0, hold_code_limit}) ? unknown_code
                                                             : code_sum[7:0];
          end
          nxt.hold_steps  = 16'd0;
          nxt.click_count = 8'd0;
          nxt.is_pressed  = 1'b0;
          nxt.is_released = 1'b0;
          nxt.is_holding  = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // reports past the per-item limit are dropped
  assign emit  = rep_gen && (rpt_cnt < bchd_pkg::RPT_CNT_W'(bchd_pkg::MAX_REPORTS));
  assign stall = emit && !rpt_ready;
  assign step  = (state == bchd_pkg::ST_MODIFY) && !stall;

  assign req.push   = step && emit;
  assign req.flush  = (state == bchd_pkg::ST_FLUSH) && rpt_ready;
  assign req.button = bchd_pkg::BIDX_W'(btn);
  assign req.kind   = rep_kind;
  assign req.code   = rep_code;

  always_comb begin
    state_next = state;
    case (state)
      bchd_pkg::ST_IDLE: begin
        if (item_fire) begin
          if (!is_tick) begin
            state_next = in_range ? bchd_pkg::ST_READ : bchd_pkg::ST_IDLE;
          end else begin
            state_next = (fire_hold || fire_rel) ? bchd_pkg::ST_READ : bchd_pkg::ST_IDLE;
          end
        end
      end
      bchd_pkg::ST_READ: begin
        state_next = bchd_pkg::ST_MODIFY;
      end
      bchd_pkg::ST_MODIFY: begin
        if (step) begin
          case (pass)
            bchd_pkg::PASS_SAMPLE:  state_next = bchd_pkg::ST_IDLE;
            bchd_pkg::PASS_HOLD: begin
              if (last_btn && !fire_rel_q) begin
                state_next = bchd_pkg::ST_FLUSH;
              end else begin
                state_next = bchd_pkg::ST_READ;
              end
            end
            bchd_pkg::PASS_RELEASE: begin
              state_next = last_btn ? bchd_pkg::ST_FLUSH : bchd_pkg::ST_READ;
            end
            default: state_next = bchd_pkg::ST_IDLE;
          endcase
        end
      end
      bchd_pkg::ST_FLUSH: begin
        if (rpt_ready) begin
          state_next = bchd_pkg::ST_IDLE;
        end
      end
      default: state_next = bchd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bchd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_samples   <= 8'd4;
      press_level        <= bchd_pkg::PRESS_LEVEL_RST;
      hold_period_ticks  <= 16'd200;
      release_wait_ticks <= 16'd500;
      click_code_limit   <= 8'd6;
      hold_code_limit    <= 8'd12;
      unknown_code       <= 8'd255;
    end else if (wr_en) begin
      case (wr_index)
        bchd_pkg::CFG_DEBOUNCE_SAMPLES:   debounce_samples   <= wr_data[7:0];
        bchd_pkg::CFG_PRESS_LEVEL:        press_level        <= wr_data[0];
        bchd_pkg::CFG_HOLD_PERIOD_TICKS:  hold_period_ticks  <= wr_data;
        bchd_pkg::CFG_RELEASE_WAIT_TICKS: release_wait_ticks <= wr_data;
        bchd_pkg::CFG_CLICK_CODE_LIMIT:   click_code_limit   <= wr_data[7:0];
        bchd_pkg::CFG_HOLD_CODE_LIMIT:    hold_code_limit    <= wr_data[7:0];
        bchd_pkg::CFG_UNKNOWN_CODE:       unknown_code       <= wr_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_timer       <= 16'd0;
      hold_timer_on    <= 1'b0;
      release_timer    <= 16'd0;
      release_timer_on <= 1'b0;
      pass             <= bchd_pkg::PASS_SAMPLE;
      btn              <= '0;
      any_pressed      <= 1'b0;
      fire_rel_q       <= 1'b0;
      rpt_cnt          <= '0;
      written          <= '0;
      rd_valid         <= 1'b0;
    end else begin
      if (item_fire) begin
        if (!is_tick) begin
          btn  <= items.button_index[AW-1:0];
          pass <= bchd_pkg::PASS_SAMPLE;
        end else begin
          btn         <= '0;
          rpt_cnt     <= '0;
          any_pressed <= 1'b0;
          fire_rel_q  <= fire_rel;
          pass        <= fire_hold ? bchd_pkg::PASS_HOLD : bchd_pkg::PASS_RELEASE;
          if (hold_timer_on) begin
            hold_timer <= hold_dec;
          end
          if (release_timer_on) begin
            if (fire_rel) begin
              release_timer    <= 16'd0;
              release_timer_on <= 1'b0;
            end else begin
              release_timer <= rel_dec;
            end
          end
        end
      end

      if (state == bchd_pkg::ST_READ) begin
        rd_valid <= written[btn];
      end

      if (step) begin
        written[btn] <= 1'b1;
        if (emit) begin
          rpt_cnt <= rpt_cnt + bchd_pkg::RPT_CNT_W'(1);
        end
        case (pass)
          bchd_pkg::PASS_SAMPLE: begin
            if (press_evt) begin
              hold_timer    <= 16'd1;
              hold_timer_on <= 1'b1;
            end
            if (release_evt) begin
              release_timer    <= bchd_pkg::at_least_one(release_wait_ticks);
              release_timer_on <= 1'b1;
            end
          end
          bchd_pkg::PASS_HOLD: begin
            any_pressed <= any_next;
            if (last_btn) begin
              // rearm while anything is held, stop otherwise
              hold_timer    <= any_next ? bchd_pkg::at_least_one(hold_period_ticks) : 16'd0;
              hold_timer_on <= any_next;
              pass          <= bchd_pkg::PASS_RELEASE;
              btn           <= '0;
            end else begin
              btn <= btn + AW'(1);
            end
          end
          bchd_pkg::PASS_RELEASE: begin
            if (!last_btn) begin
              btn <= btn + AW'(1);
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      level <= items.pin_level;
    end
  end

  bchd_ram #(
    .WIDTH (SW),
    .DEPTH (BUTTONS)
  ) u_state_ram (
    .clk   (clk),
    .we    (step),
    .waddr (btn),
    .wdata (nxt),
    .re    (state == bchd_pkg::ST_READ),
    .raddr (btn),
    .rdata (ram_q)
  );

endmodule

// ----- design/button_click_and_hold_detector.sv -----
// A pin sample passes through accept, state read and write back, and gives no report.
// A tick is accepted; each timer that fires makes a pass over all buttons (hold pass, then
// release pass over the per-button state memory), and then the last report is marked.
// Reset: configuration takes its default values, timers stop, and per-button valid bits
// clear so that every button reads its reset state; no clearing pass is needed.
module button_click_and_hold_detector #(
  parameter int BUTTONS = bchd_pkg::BUTTONS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [bchd_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [bchd_pkg::CFG_DATA_W-1:0] wr_data,
  bchd_item_if.sink                       items,
  bchd_report_if.source                   reports
);

  bchd_pkg::rpt_req_t rpt_req;
  logic               rpt_ready;

  bchd_ctrl #(
    .BUTTONS (BUTTONS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .items     (items),
    .req       (rpt_req),
    .rpt_ready (rpt_ready)
  );

  bchd_rpt u_rpt (
    .clk     (clk),
    .rst     (rst),
    .req     (rpt_req),
    .ready   (rpt_ready),
    .reports (reports)
  );

endmodule

// ----- test/button_click_and_hold_detector_tb.sv -----
`timescale 1ns / 1ps

module button_click_and_hold_detector_tb;
  import bchd_pkg::*;

  localparam int BUTTONS       = 4;
  localparam int SETTLE_CYCLES = 2 + 4 * BUTTONS + 8;
  localparam int STALL_LIMIT   = 1000;

  typedef struct packed {
    logic       op;
    logic [3:0] button;
    logic       level;
  } item_t;

  typedef struct packed {
    logic [3:0]   button;
    report_kind_t kind;
    logic [7:0]   code;
    logic         last;
  } report_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  wr_en;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  bchd_item_if   items ();
  bchd_report_if reports ();

  button_click_and_hold_detector #(.BUTTONS(BUTTONS)) dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .items    (items),
    .reports  (reports)
  );

  always #2 clk = ~clk;

  // configuration mirror
  logic [7:0]  cfg_debounce;
  logic        cfg_press_level;
  logic [15:0] cfg_hold_period;
  logic [15:0] cfg_release_wait;
  logic [7:0]  cfg_click_limit;
  logic [7:0]  cfg_hold_limit;
  logic [7:0]  cfg_unknown;

  // per-button and shared detector state
  logic        stable_lvl  [BUTTONS];
  logic        last_sample [BUTTONS];
  logic [7:0]  run_len     [BUTTONS];
  logic [7:0]  clicks      [BUTTONS];
  logic [15:0] steps       [BUTTONS];
  logic        pressed     [BUTTONS];
  logic        released    [BUTTONS];
  logic        holding     [BUTTONS];
  logic [15:0] hold_cnt;
  logic        hold_on;
  logic [15:0] rel_cnt;
  logic        rel_on;

  item_t   pending_items[$];
  report_t expected_reports[$];

  int errors       = 0;
  int stall_cycles = 0;
  int send_gap     = 0;
  int recv_gap     = 0;
  bit item_taken   = 1'b0;
  bit calm         = 1'b0;

  function automatic void predict_reports(input logic op, input logic [3:0] button,
                                          input logic level);
    report_t found [MAX_REPORTS];
    int      n;
    int      b;
    int      i;
    int      code;
    bit      any;
    n   = 0;
    any = 1'b0;
    if (op == OP_SAMPLE) begin
      if (button < BUTTONS) begin
        b = button;
        if (level == last_sample[b]) begin
          if (run_len[b] != 8'hFF) run_len[b]++;
        end else begin
          run_len[b] = 8'd1;
        end
        last_sample[b] = level;
        if (run_len[b] >= cfg_debounce && level != stable_lvl[b]) begin
          stable_lvl[b] = level;
          if (level == cfg_press_level) begin
            if (clicks[b] != 8'hFF) clicks[b]++;
            // a new press makes the hold timer fire on the next tick
            hold_cnt    = 16'd1;
            hold_on     = 1'b1;
            holding[b]  = 1'b0;
            steps[b]    = 16'd0;
            pressed[b]  = 1'b1;
            released[b] = 1'b0;
          end else begin
            released[b] = 1'b1;
            pressed[b]  = 1'b0;
            rel_cnt     = (cfg_release_wait == 16'd0) ? 16'd1 : cfg_release_wait;
            rel_on      = 1'b1;
          end
        end
      end
    end else begin
      if (hold_on) begin
        if (hold_cnt != 16'd0) hold_cnt--;
        if (hold_cnt == 16'd0) begin
          for (i = 0; i < BUTTONS; i++) begin
            if (pressed[i]) begin
              any = 1'b1;
              if (steps[i] != 16'hFFFF) steps[i]++;
              if (steps[i] >= HOLD_STEP_DIV) begin
                holding[i] = 1'b1;
                clicks[i]  = 8'd0;
              end
              if (steps[i] % HOLD_STEP_DIV == 0) begin
                code = steps[i] / HOLD_STEP_DIV + cfg_click_limit;
                found[n] = '{button: i[3:0], kind: KIND_HOLD_PROGRESS,
                             code: (code > 255) ? 8'hFF : code[7:0], last: 1'b0};
                n++;
              end
            end
          end
          // stop the timer once nothing is pressed
          if (any) hold_cnt = (cfg_hold_period == 16'd0) ? 16'd1 : cfg_hold_period;
          else     hold_cnt = 16'd0;
          hold_on = any;
        end
      end
      if (rel_on) begin
        if (rel_cnt != 16'd0) rel_cnt--;
        if (rel_cnt == 16'd0) begin
          rel_on = 1'b0;
          for (i = 0; i < BUTTONS; i++) begin
            if (released[i]) begin
              if (!holding[i]) begin
                code = clicks[i];
                found[n] = '{button: i[3:0], kind: KIND_CLICK_COUNT,
                             code: (code >= cfg_click_limit) ? cfg_unknown : code[7:0],
                             last: 1'b0};
              end else begin
                code = steps[i] / HOLD_STEP_DIV + cfg_click_limit;
                found[n] = '{button: i[3:0], kind: KIND_HOLD_CODE,
                             code: (code >= cfg_hold_limit) ? cfg_unknown : code[7:0],
                             last: 1'b0};
              end
              n++;
              steps[i]    = 16'd0;
              clicks[i]   = 8'd0;
              pressed[i]  = 1'b0;
              released[i] = 1'b0;
              holding[i]  = 1'b0;
            end
          end
        end
      end
    end
    for (i = 0; i < n; i++) begin
      found[i].last = (i == n - 1);
      expected_reports.push_back(found[i]);
    end
  endfunction

  task automatic push_item(input logic op, input logic [3:0] button, input logic level);
    pending_items.push_back('{op: op, button: button, level: level});
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(negedge clk);
    wr_en <= 1'b0;
    case (idx)
      CFG_DEBOUNCE_SAMPLES:   cfg_debounce     = val[7:0];
      CFG_PRESS_LEVEL:        cfg_press_level  = val[0];
      CFG_HOLD_PERIOD_TICKS:  cfg_hold_period  = val;
      CFG_RELEASE_WAIT_TICKS: cfg_release_wait = val;
      CFG_CLICK_CODE_LIMIT:   cfg_click_limit  = val[7:0];
      CFG_HOLD_CODE_LIMIT:    cfg_hold_limit   = val[7:0];
      CFG_UNKNOWN_CODE:       cfg_unknown      = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [7:0] debounce, input logic press_level,
                            input logic [15:0] hold_period, input logic [15:0] release_wait,
                            input logic [7:0] click_limit, input logic [7:0] hold_limit,
                            input logic [7:0] unknown);
    write_reg(CFG_DEBOUNCE_SAMPLES, {8'd0, debounce});
    write_reg(CFG_PRESS_LEVEL, {15'd0, press_level});
    write_reg(CFG_HOLD_PERIOD_TICKS, hold_period);
    write_reg(CFG_RELEASE_WAIT_TICKS, release_wait);
    write_reg(CFG_CLICK_CODE_LIMIT, {8'd0, click_limit});
    write_reg(CFG_HOLD_CODE_LIMIT, {8'd0, hold_limit});
    write_reg(CFG_UNKNOWN_CODE, {8'd0, unknown});
  endtask

  // mostly clean presses and releases with tick runs between, plus glitches and noise
  task automatic queue_random(input int count);
    int   added;
    int   n;
    int   pick;
    int   b;
    logic lvl;
    added = 0;
    while (added < count) begin
      pick = $urandom_range(0, 9);
      b    = $urandom_range(0, BUTTONS - 1);
      lvl  = 1'($urandom_range(0, 1));
      case (pick)
        0, 1, 2, 3: begin
          n = cfg_debounce + $urandom_range(0, 1);
          repeat (n) push_item(OP_SAMPLE, b[3:0], lvl);
        end
        4, 5: begin
          n = $urandom_range(1, 6);
          repeat (n) push_item(OP_TICK, 4'($urandom_range(0, 15)),
                               1'($urandom_range(0, 1)));
        end
        6: begin
          n = $urandom_range(10, 40);
          repeat (n) push_item(OP_TICK, 4'($urandom_range(0, 15)),
                               1'($urandom_range(0, 1)));
        end
        7: begin
          n = 2;
          push_item(OP_SAMPLE, b[3:0], lvl);
          push_item(OP_SAMPLE, b[3:0], ~lvl);
        end
        default: begin
          n = 1;
          push_item(OP_SAMPLE, 4'($urandom_range(0, 15)), lvl);
        end
      endcase
      added += n;
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_items.size() != 0 || items.valid || expected_reports.size() != 0);
    // samples give no report, so let the pipeline empty
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(negedge clk) begin : driver
    item_t nxt;
    if (rst) begin
      items.valid <= 1'b0;
    end else if (!items.valid || item_taken) begin
      if (send_gap != 0) begin
        send_gap    <= send_gap - 1;
        items.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        send_gap    <= $urandom_range(0, 7);
        items.valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        nxt                = pending_items.pop_front();
        items.op           <= nxt.op;
        items.button_index <= nxt.button;
        items.pin_level    <= nxt.level;
        items.valid        <= 1'b1;
      end else begin
        items.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : receiver
    if (recv_gap != 0) begin
      recv_gap      <= recv_gap - 1;
      reports.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      recv_gap      <= $urandom_range(0, 7);
      reports.ready <= 1'b0;
    end else begin
      reports.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : monitor
    report_t want;
    item_taken <= !rst && items.valid && items.ready;
    if (!rst && items.valid && items.ready)
      predict_reports(items.op, items.button_index, items.pin_level);
    if (!rst && reports.valid && reports.ready) begin
      if (expected_reports.size() == 0) begin
        $error("unexpected report: button_index_res %0d report_kind %0d report_code %0d",
               reports.button_index_res, reports.report_kind, reports.report_code);
        errors++;
      end else begin
        want = expected_reports.pop_front();
        if (reports.button_index_res !== want.button) begin
          $error("button_index_res: expected %0d, got %0d", want.button,
                 reports.button_index_res);
          errors++;
        end
        if (reports.report_kind !== want.kind) begin
          $error("report_kind: expected %0d, got %0d", want.kind, reports.report_kind);
          errors++;
        end
        if (reports.report_code !== want.code) begin
          $error("report_code: expected %0d, got %0d", want.code, reports.report_code);
          errors++;
        end
        if (reports.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, reports.last);
          errors++;
        end
      end
    end
    if ((items.valid && items.ready) || (reports.valid && reports.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("button_click_and_hold_detector_tb: done, errors");
    $finish;
  end

  initial begin : sequencer
    int i;
    items.valid        = 1'b0;
    items.op           = OP_SAMPLE;
    items.button_index = 4'd0;
    items.pin_level    = 1'b0;
    reports.ready      = 1'b0;
    wr_en              = 1'b0;
    wr_index           = CFG_DEBOUNCE_SAMPLES;
    wr_data            = '0;

    cfg_debounce     = 8'd4;
    cfg_press_level  = PRESS_LEVEL_RST;
    cfg_hold_period  = 16'd200;
    cfg_release_wait = 16'd500;
    cfg_click_limit  = 8'd6;
    cfg_hold_limit   = 8'd12;
    cfg_unknown      = 8'd255;
    for (i = 0; i < BUTTONS; i++) begin
      stable_lvl[i]  = ~PRESS_LEVEL_RST;
      last_sample[i] = ~PRESS_LEVEL_RST;
      run_len[i]     = 8'd0;
      clicks[i]      = 8'd0;
      steps[i]       = 16'd0;
      pressed[i]     = 1'b0;
      released[i]    = 1'b0;
      holding[i]     = 1'b0;
    end
    hold_cnt = 16'd0;
    hold_on  = 1'b0;
    rel_cnt  = 16'd0;
    rel_on   = 1'b0;

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // reset values: an ignored button, a debounced press, a tick with odd ignored fields
    push_item(OP_SAMPLE, 4'd15, 1'b0);
    repeat (4) push_item(OP_SAMPLE, 4'd0, 1'b0);
    push_item(OP_TICK, 4'd15, 1'b1);
    wait_idle();

    set_config(8'd1, 1'b0, 16'd1, 16'd3, 8'd6, 8'd12, 8'd255);
    // hold progress, release after hold, multi-click, and both timers on one tick
    push_item(OP_SAMPLE, 4'd1, 1'b0);
    repeat (5) push_item(OP_TICK, 4'd0, 1'b0);
    push_item(OP_SAMPLE, 4'd1, 1'b1);
    push_item(OP_SAMPLE, 4'd0, 1'b1);
    repeat (3) push_item(OP_TICK, 4'd0, 1'b0);
    push_item(OP_SAMPLE, 4'd2, 1'b0);
    push_item(OP_SAMPLE, 4'd2, 1'b1);
    push_item(OP_SAMPLE, 4'd2, 1'b0);
    push_item(OP_SAMPLE, 4'd2, 1'b1);
    repeat (3) push_item(OP_TICK, 4'd0, 1'b0);
    queue_random(10);
    wait_idle();

    // zero periods act as one tick
    set_config(8'd2, 1'b1, 16'd0, 16'd0, 8'd3, 8'd5, 8'hAA);
    queue_random(6);
    wait_idle();

    set_config(8'd3, 1'b0, 16'd2, 16'd6, 8'd255, 8'd255, 8'h55);
    queue_random(6);
    wait_idle();

    // longest debounce; the run length saturates
    set_config(8'd255, 1'b1, 16'hFFFF, 16'hFFFF, 8'd0, 8'd0, 8'd0);
    repeat (256) push_item(OP_SAMPLE, 4'd2, 1'b1);
    repeat (4) push_item(OP_TICK, 4'd0, 1'b0);
    wait_idle();

    // hold codes run past 255 here
    calm = 1'b1;
    set_config(8'd1, 1'b0, 16'd1, 16'd2, 8'd254, 8'd255, 8'hFF);
    push_item(OP_SAMPLE, 4'd0, 1'b1);
    push_item(OP_SAMPLE, 4'd0, 1'b0);
    repeat (11) push_item(OP_TICK, 4'd0, 1'b0);
    push_item(OP_SAMPLE, 4'd0, 1'b1);
    repeat (2) push_item(OP_TICK, 4'd0, 1'b0);
    queue_random(4);
    wait_idle();

    if (errors == 0)
      $display("button_click_and_hold_detector_tb: done, clean");
    else
      $display("button_click_and_hold_detector_tb: done, errors");
    $finish;
  end

endmodule

// ----- button_click_and_hold_detector.f -----
design/bchd_pkg.sv
design/bchd_if.sv
design/bchd_ram.sv
design/bchd_rpt.sv
design/bchd_ctrl.sv
design/button_click_and_hold_detector.sv
test/button_click_and_hold_detector_tb.sv
